@@ src/tws_pkg.sv @@
package tws_pkg;

	localparam int SECS_PER_MIN  = 60;
	localparam int SECS_PER_HOUR = SECS_PER_MIN * SECS_PER_MIN;

	localparam int SECS_W   = 17;  // up to 31*3600 + 63*60 + 63
	localparam int DUR_W    = 16;
	localparam int TARGET_W = 3;
	localparam int HITS_W   = 8;
	localparam int RELAY_W  = 2;

	// command codes
	localparam logic CMD_EVAL  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_MANUAL = 1'b0;

	typedef struct packed {
		logic                enabled;
		logic [SECS_W-1:0]   open_secs;
		logic [DUR_W-1:0]    duration;
		logic [TARGET_W-1:0] target;
	} event_entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_DONE
	} scan_state_t;

	function automatic logic [SECS_W-1:0] day_secs(
		input logic [4:0] h,
		input logic [5:0] m,
		input logic [5:0] s
	);
		return SECS_W'(h) * SECS_W'(SECS_PER_HOUR) + SECS_W'(m) * SECS_W'(SECS_PER_MIN)
			+ SECS_W'(s);
	endfunction

endpackage

@@ src/tws_ram.sv @@
module tws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/tws_table.sv @@
module tws_table
	import tws_pkg::*;
#(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [AW-1:0] wr_addr,
	input  event_entry_t wr_data,
	input  logic         rd_en,
	input  logic [AW-1:0] rd_addr,
	output event_entry_t rd_data
);

	logic [DEPTH-1:0] vld_q;
	logic             vld_s1;
	logic [$bits(event_entry_t)-1:0] ram_rdata;

	tws_ram #(
		.WIDTH ($bits(event_entry_t)),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// entries never written since reset read as a cleared, disabled event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = vld_s1 ? event_entry_t'(ram_rdata) : '0;

endmodule

@@ src/tws_ctrl.sv @@
module tws_ctrl
	import tws_pkg::*;
#(
	parameter int EVENT_COUNT = 8,
	parameter int RELAY_COUNT = 2,
	parameter int AW          = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [SECS_W-1:0]  now_secs,
	input  logic               button,
	input  logic [RELAY_W-1:0] manual,
	output logic               idle,
	output logic               rd_en,
	output logic [AW-1:0]      rd_addr,
	input  event_entry_t       rd_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [RELAY_W-1:0] relay_drive,
	output logic [HITS_W-1:0]  window_hits
);

	scan_state_t state_q, state_d;

	logic [AW-1:0]      rd_idx_q;
	logic               rd_en_s1;
	logic [SECS_W-1:0]  now_q;
	logic               button_q;
	logic [HITS_W-1:0]  hits_q;
	logic               out_valid_q;
	logic [RELAY_W-1:0] drive_q;
	logic [HITS_W-1:0]  hits_out_q;
	logic               last_idx;
	logic               load;
	logic [SECS_W:0]    end_secs;
	logic               hit;
	logic [RELAY_W-1:0] drive_d;

	assign last_idx = rd_idx_q == AW'(EVENT_COUNT - 1);
	assign load     = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				if (last_idx) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rd_addr = rd_idx_q;
	assign idle    = state_q == ST_IDLE;

	// window is open-ended on both sides: start < now < start + duration
	assign end_secs = {1'b0, rd_data.open_secs} + (SECS_W + 1)'(rd_data.duration);
	assign hit      = rd_data.enabled && (rd_data.open_secs < now_q)
		&& (end_secs > {1'b0, now_q});

	always_comb begin
		for (int i = 0; i < RELAY_W; i++) begin
			drive_d[i] = (i < RELAY_COUNT) && (manual[i] || hits_q[i] || button_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q    <= '0;
			rd_en_s1    <= 1'b0;
			hits_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_en_s1 <= rd_en;
			if (state_q == ST_IDLE) begin
				rd_idx_q <= '0;
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (start) begin
				hits_q <= '0;
			end else if (rd_en_s1 && hit) begin
				hits_q <= hits_q | (HITS_W'(1) << rd_data.target);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			now_q    <= now_secs;
			button_q <= button;
		end
		if (load) begin
			drive_q    <= drive_d;
			hits_out_q <= hits_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign relay_drive = drive_q;
	assign window_hits = hits_out_q;

endmodule

@@ src/time_window_relay_scheduler.sv @@
// channel   | handshake               | word
// ----------+-------------------------+-------------------------------------------
// input     | in_valid / in_ready     | command, time of day, button, event entry
// output    | out_valid / out_ready   | relay_drive, window_hits
// config    | APB, pready tied high   | manual_relay_bits at byte address 0
//
// A write word leaves in_ready high; the next word can follow at once.
// An evaluate word scans the table one entry per cycle and then registers its result;
// the next word is taken once that result loads.
// in_ready is low from an evaluate accept until its result loads; the load waits
// while an older result is still stalled on out_ready.
// Reset clears the table through per-entry valid flops: no clearing pass.
module time_window_relay_scheduler
	import tws_pkg::*;
#(
	parameter int EVENT_COUNT = 8,
	parameter int RELAY_COUNT = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                command,
	input  logic [4:0]          now_hour,
	input  logic [5:0]          now_minute,
	input  logic [5:0]          now_second,
	input  logic                button_pressed,
	input  logic [2:0]          event_slot,
	input  logic                event_enabled,
	input  logic [4:0]          start_hour,
	input  logic [5:0]          start_minute,
	input  logic [5:0]          start_second,
	input  logic [15:0]         duration_seconds,
	input  logic [2:0]          target_relay,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [RELAY_W-1:0]  relay_drive,
	output logic [HITS_W-1:0]   window_hits
);

	localparam int AW = (EVENT_COUNT > 1) ? $clog2(EVENT_COUNT) : 1;

	logic [RELAY_W-1:0] manual_q;
	logic               accept;
	logic               start;
	logic               wr_en;
	event_entry_t       wr_entry;
	logic [SECS_W-1:0]  now_secs;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	event_entry_t       rd_data;
	logic               idle;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			manual_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == REG_MANUAL) begin
			manual_q <= pwdata[RELAY_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_MANUAL) ? 32'(manual_q) : '0;

	assign in_ready = idle;
	assign accept   = in_valid && in_ready;
	assign start    = accept && command == CMD_EVAL;
	// slots past the table are dropped
	assign wr_en    = accept && command == CMD_WRITE && (int'(event_slot) < EVENT_COUNT);

	assign now_secs            = day_secs(now_hour, now_minute, now_second);
	assign wr_entry.enabled    = event_enabled;
	assign wr_entry.open_secs  = day_secs(start_hour, start_minute, start_second);
	assign wr_entry.duration   = duration_seconds;
	assign wr_entry.target     = target_relay;

	tws_table #(
		.DEPTH (EVENT_COUNT),
		.AW    (AW)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (AW'(event_slot)),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	tws_ctrl #(
		.EVENT_COUNT (EVENT_COUNT),
		.RELAY_COUNT (RELAY_COUNT),
		.AW          (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.now_secs    (now_secs),
		.button      (button_pressed),
		.manual      (manual_q),
		.idle        (idle),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.relay_drive (relay_drive),
		.window_hits (window_hits)
	);

endmodule

@@ src/tws_checker.sv @@
module tws_checker
	import tws_pkg::*;
#(
	parameter int RELAY_COUNT = 2
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               command,
	input logic               out_valid,
	input logic               out_ready,
	input logic [RELAY_W-1:0] relay_drive,
	input logic [HITS_W-1:0]  window_hits
);

	// an evaluate word blocks the input while the table is scanned
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && command == CMD_EVAL) |=> !in_ready)
		else $error("input ready right after evaluate word");

	// a write word never produces a result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && command == CMD_WRITE && !out_valid) |=> !out_valid)
		else $error("result after write word");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(relay_drive)
			&& $stable(window_hits)))
		else $error("output word changed while stalled");

	a_relay_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((32'(relay_drive) >> RELAY_COUNT) == 32'd0))
		else $error("drive on relay past relay count");

endmodule

bind time_window_relay_scheduler tws_checker #(.RELAY_COUNT(RELAY_COUNT)) u_tws_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.command     (command),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.relay_drive (relay_drive),
	.window_hits (window_hits)
);
